// File: rtl/core/keypad_encoder_event_queue_macros.svh
// assertion macros for the keypad encoder event queue
`ifndef KEYPAD_ENCODER_EVENT_QUEUE_MACROS_SVH
`define KEYPAD_ENCODER_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KEE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define KEE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/kee_pkg.sv
// types and constants shared by the keypad encoder event queue
`timescale 1ns / 1ps
package kee_pkg;

	localparam int ROWS            = 5;
	localparam int COLUMNS         = 5;
	localparam int NPOS            = ROWS * COLUMNS;
	localparam int POS_W           = $clog2(NPOS);
	localparam int QUEUE_DEPTH_DEF = 128;

	localparam int CODE_W      = 5;
	localparam int COUNT_W     = 8;
	localparam int MASK_W      = 25;
	localparam int GUARD_W     = 16;
	localparam int TIME_W      = 32;
	localparam int CFG_DATA_W  = 25;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CODE_W-1:0] CODE_LEFT   = CODE_W'(NPOS);
	localparam logic [CODE_W-1:0] CODE_RIGHT  = CODE_W'(NPOS + 1);
	localparam logic [CODE_W-1:0] CODE_BUTTON = CODE_W'(NPOS + 2);

	localparam logic [MASK_W-1:0]  VALID_KEY_MASK_RST = 25'h379DFF;
	localparam logic [GUARD_W-1:0] RELEASE_GUARD_RST  = 16'd100;
	localparam logic [GUARD_W-1:0] BUTTON_GUARD_RST   = 16'd100;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VALID_KEY_MASK = 2'd0,
		REG_RELEASE_GUARD  = 2'd1,
		REG_BUTTON_GUARD   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_SCAN = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [MASK_W-1:0] key_levels;
		logic              enc_a;
		logic              enc_b;
		logic              enc_button_level;
		logic [TIME_W-1:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic               event_valid;
		logic [CODE_W-1:0]  event_code;
		logic [COUNT_W-1:0] queue_count;
		logic               overflow;
	} out_word_t;

	typedef struct packed {
		logic [MASK_W-1:0]  valid_key_mask;
		logic [GUARD_W-1:0] release_guard_ms;
		logic [GUARD_W-1:0] button_guard_ms;
	} cfg_t;

	// head of the front queue as seen by the back end
	typedef struct packed {
		logic     valid;
		logic     pop;
		in_word_t word;
	} head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYS,
		ST_ENC,
		ST_BTN,
		ST_POP,
		ST_POP_DATA,
		ST_DONE
	} back_state_t;

endpackage

// File: rtl/core/kee_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module kee_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/kee_front.sv
// front end: two-word input queue that accepts and classifies items
`timescale 1ns / 1ps
module kee_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  kee_pkg::in_word_t in_word,
	output kee_pkg::head_t    head,
	input  logic              take
);
	import kee_pkg::*;

	in_word_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign pop      = take && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_word;
		end
	end

	always_comb begin
		head.valid = (cnt_q != 2'd0);
		head.word  = mem_q[rd_q];
		head.pop   = (mem_q[rd_q].cmd == CMD_POP);
	end

endmodule

// File: rtl/core/kee_back.sv
// back end: scan sequencer, event queue and result register
`timescale 1ns / 1ps
module kee_back #(
	parameter int QUEUE_DEPTH = kee_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kee_pkg::cfg_t      cfg,
	input  kee_pkg::head_t     head,
	output logic               take,
	output logic               out_valid,
	input  logic               out_stall,
	output kee_pkg::out_word_t out_word
);
	import kee_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	back_state_t       state_q, state_d;
	in_word_t          cur_q;
	logic [POS_W-1:0]  pos_q;
	logic [TIME_W-1:0] press_time_q [NPOS];
	logic [NPOS-1:0]   key_held_q;
	logic              armed_q;
	logic              btn_prev_q;
	logic [TIME_W-1:0] btn_time_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic              res_valid_q;
	logic [CODE_W-1:0] res_code_q;
	logic              res_ovf_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic              out_free;
	logic              full;
	logic              push_req;
	logic [CODE_W-1:0] push_code;
	logic              pop_en;
	logic              set_held;
	logic              clr_held;
	logic              arm_set;
	logic              arm_clr;
	logic              btn_upd;
	logic              btn_now;
	logic              capture;
	logic              load_out;
	logic [TIME_W-1:0] key_elapsed;
	logic [TIME_W-1:0] btn_elapsed;
	logic [CODE_W-1:0] ram_rdata;
	logic [PTR_W-1:0]  head_next;
	logic [PTR_W-1:0]  tail_next;

	assign out_free    = !out_valid_q || !out_stall;
	assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
	assign key_elapsed = cur_q.now_ms - press_time_q[pos_q];
	assign btn_elapsed = cur_q.now_ms - btn_time_q;
	assign btn_now     = !cur_q.enc_button_level;
	assign head_next   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next   = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		push_req  = 1'b0;
		push_code = '0;
		pop_en    = 1'b0;
		set_held  = 1'b0;
		clr_held  = 1'b0;
		arm_set   = 1'b0;
		arm_clr   = 1'b0;
		btn_upd   = 1'b0;
		capture   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					take    = 1'b1;
					state_d = head.pop ? ST_POP : ST_KEYS;
				end
			end
			ST_KEYS: begin
				if (cfg.valid_key_mask[pos_q]) begin
					if (key_held_q[pos_q]) begin
						// release only once the guard time has run out
						if ((key_elapsed > TIME_W'(cfg.release_guard_ms)) &&
								cur_q.key_levels[pos_q]) begin
							clr_held = 1'b1;
						end
					end else if (!cur_q.key_levels[pos_q]) begin
						set_held  = 1'b1;
						push_req  = 1'b1;
						push_code = CODE_W'(pos_q);
					end
				end
				if (pos_q == POS_W'(NPOS - 1)) begin
					state_d = ST_ENC;
				end
			end
			ST_ENC: begin
				if (cur_q.enc_a && cur_q.enc_b) begin
					arm_set = 1'b1;
				end else if (armed_q && cur_q.enc_a && !cur_q.enc_b) begin
					arm_clr   = 1'b1;
					push_req  = 1'b1;
					push_code = CODE_LEFT;
				end else if (armed_q && !cur_q.enc_a && cur_q.enc_b) begin
					arm_clr   = 1'b1;
					push_req  = 1'b1;
					push_code = CODE_RIGHT;
				end
				state_d = ST_BTN;
			end
			ST_BTN: begin
				// button is not sampled during the lockout
				if ((btn_elapsed >= TIME_W'(cfg.button_guard_ms)) && (btn_now != btn_prev_q)) begin
					btn_upd   = 1'b1;
					push_req  = btn_now;
					push_code = CODE_BUTTON;
				end
				state_d = ST_DONE;
			end
			ST_POP: begin
				if (count_q != '0) begin
					pop_en  = 1'b1;
					state_d = ST_POP_DATA;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_POP_DATA: begin
				capture = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			key_held_q  <= '0;
			armed_q     <= 1'b0;
			btn_prev_q  <= 1'b0;
			btn_time_q  <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			res_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				pos_q       <= '0;
				res_valid_q <= 1'b0;
				res_ovf_q   <= 1'b0;
			end else if (state_q == ST_KEYS) begin
				pos_q <= pos_q + 1'b1;
			end
			if (set_held) begin
				key_held_q[pos_q] <= 1'b1;
			end
			if (clr_held) begin
				key_held_q[pos_q] <= 1'b0;
			end
			if (arm_set) begin
				armed_q <= 1'b1;
			end else if (arm_clr) begin
				armed_q <= 1'b0;
			end
			if (btn_upd) begin
				btn_prev_q <= btn_now;
				btn_time_q <= cur_q.now_ms;
			end
			if (push_req) begin
				if (full) begin
					res_ovf_q <= 1'b1;
				end else begin
					tail_q  <= tail_next;
					count_q <= count_q + 1'b1;
				end
			end
			if (pop_en) begin
				head_q  <= head_next;
				count_q <= count_q - 1'b1;
			end
			if (capture) begin
				res_valid_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q      <= head.word;
			res_code_q <= '0;
		end
		if (set_held) begin
			press_time_q[pos_q] <= cur_q.now_ms;
		end
		if (capture) begin
			res_code_q <= ram_rdata;
		end
		if (load_out) begin
			out_word_q.event_valid <= res_valid_q;
			out_word_q.event_code  <= res_code_q;
			out_word_q.queue_count <= COUNT_W'(count_q);
			out_word_q.overflow    <= res_ovf_q;
		end
	end

	kee_ram #(
		.WIDTH (CODE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (push_req && !full),
		.waddr (tail_q),
		.wdata (push_code),
		.re    (pop_en),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// File: rtl/core/keypad_encoder_event_queue.sv
// top level: keypad matrix scanner with encoder, button and event queue
`timescale 1ns / 1ps
// Items go into a two-word input queue and are handled one at a time by a
// sequencer. A scan word passes through a fetch step, one step per matrix
// position (25) with a single release-time compare each, one for the encoder,
// one for the button and one to load the result register. A pop word passes
// through fetch, pop, the registered read of the event store and the load,
// skipping the read when the event queue is empty. Results sit in an output
// register, so the input side keeps filling while a result waits. The event
// store needs no clearing after reset. Configuration registers take effect on
// the next word if written between words; the block does not enforce this.
module keypad_encoder_event_queue #(
	parameter int QUEUE_DEPTH = kee_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [kee_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [kee_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  kee_pkg::in_word_t                    in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output kee_pkg::out_word_t                   out_word
);
	import kee_pkg::*;

	`include "keypad_encoder_event_queue_macros.svh"

	cfg_t  cfg_q;
	head_t head;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valid_key_mask   <= VALID_KEY_MASK_RST;
			cfg_q.release_guard_ms <= RELEASE_GUARD_RST;
			cfg_q.button_guard_ms  <= BUTTON_GUARD_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_VALID_KEY_MASK: cfg_q.valid_key_mask   <= MASK_W'(cfg_data);
				REG_RELEASE_GUARD:  cfg_q.release_guard_ms <= GUARD_W'(cfg_data);
				REG_BUTTON_GUARD:   cfg_q.button_guard_ms  <= GUARD_W'(cfg_data);
				default:            cfg_q                  <= cfg_q;
			endcase
		end
	end

	kee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.head     (head),
		.take     (take)
	);

	kee_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	`KEE_ASSERT_NOW(a_take_needs_head, take, head.valid, "back end took from an empty queue")
	`KEE_ASSERT_NOW(a_stall_means_held, in_stall, head.valid, "input stalled with nothing queued")
	`KEE_ASSERT_NOW(a_pop_result_clean, out_valid && out_word.event_valid, !out_word.overflow && (out_word.event_code <= CODE_BUTTON), "popped word carries overflow or a bad code")
	`KEE_ASSERT_NEXT(a_take_starts_work, take, !take, "two words taken in successive cycles")

endmodule

// File: tb/testbench.sv
// self-checking testbench for the keypad encoder event queue
`timescale 1ns / 1ps
module testbench;
	import kee_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 40;
	localparam logic [MASK_W-1:0] ALL_UP = '1;
	localparam logic [MASK_W-1:0] ALL_DOWN = '0;

	typedef struct packed {
		in_word_t  word;
		logic      typed;
		out_word_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_word_t in_word;
	logic out_valid;
	logic out_stall;
	out_word_t out_word;

	keypad_encoder_event_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// scanner model: configuration, key and encoder state, queued event codes
	logic [MASK_W-1:0] key_mask = VALID_KEY_MASK_RST;
	logic [GUARD_W-1:0] release_guard = RELEASE_GUARD_RST;
	logic [GUARD_W-1:0] button_guard = BUTTON_GUARD_RST;
	logic [TIME_W-1:0] press_at [NPOS];
	logic [NPOS-1:0] keys_held = '0;
	logic enc_armed = 1'b0;
	logic btn_prev = 1'b0;
	logic [TIME_W-1:0] btn_changed_at = '0;
	logic [CODE_W-1:0] queued_codes [$];

	out_word_t expected_results [$];

	// random scan source: a time base, key levels, encoder phase and button level
	logic [TIME_W-1:0] sim_now = '0;
	logic [MASK_W-1:0] sim_keys = '1;
	logic [1:0] sim_enc_step = 2'd0;
	logic sim_button = 1'b1;

	int unsigned idle_pct = 30;
	int unsigned stall_run = 0;
	int unsigned failures = 0;
	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned events_popped = 0;
	int unsigned overflow_scans = 0;
	int unsigned writes_done = 0;

	initial begin
		for (int p = 0; p < NPOS; p++)
			press_at[p] = '0;
	end

	function automatic bit log_event(logic [CODE_W-1:0] code);
		if (queued_codes.size() >= QUEUE_DEPTH_DEF)
			return 1'b0;
		queued_codes.push_back(code);
		return 1'b1;
	endfunction

	function automatic out_word_t scan_or_pop(in_word_t w);
		out_word_t r;
		logic [TIME_W-1:0] since;
		logic pressed;
		r = '0;
		if (w.cmd == CMD_POP) begin
			if (queued_codes.size() != 0) begin
				r.event_valid = 1'b1;
				r.event_code = queued_codes.pop_front();
			end
		end else begin
			for (int p = 0; p < NPOS; p++) begin
				if (key_mask[p]) begin
					if (keys_held[p]) begin
						since = w.now_ms - press_at[p];
						if (since > TIME_W'(release_guard) && w.key_levels[p])
							keys_held[p] = 1'b0;
					end else if (!w.key_levels[p]) begin
						keys_held[p] = 1'b1;
						press_at[p] = w.now_ms;
						if (!log_event(CODE_W'(p)))
							r.overflow = 1'b1;
					end
				end
			end
			// a detent counts only once both lines have been seen high
			if (w.enc_a && w.enc_b) begin
				enc_armed = 1'b1;
			end else if (enc_armed && w.enc_a && !w.enc_b) begin
				enc_armed = 1'b0;
				if (!log_event(CODE_LEFT))
					r.overflow = 1'b1;
			end else if (enc_armed && !w.enc_a && w.enc_b) begin
				enc_armed = 1'b0;
				if (!log_event(CODE_RIGHT))
					r.overflow = 1'b1;
			end
			pressed = !w.enc_button_level;
			since = w.now_ms - btn_changed_at;
			if (since >= TIME_W'(button_guard) && pressed != btn_prev) begin
				btn_prev = pressed;
				if (pressed && !log_event(CODE_BUTTON))
					r.overflow = 1'b1;
				btn_changed_at = w.now_ms;
			end
		end
		r.queue_count = COUNT_W'(queued_codes.size());
		return r;
	endfunction

	function automatic in_word_t make_word(cmd_t c, logic [MASK_W-1:0] levels, logic a,
			logic b, logic btn_level, logic [TIME_W-1:0] now);
		in_word_t w;
		w.cmd = c;
		w.key_levels = levels;
		w.enc_a = a;
		w.enc_b = b;
		w.enc_button_level = btn_level;
		w.now_ms = now;
		return w;
	endfunction

	function automatic out_word_t result_word(logic valid, logic [CODE_W-1:0] code,
			logic [COUNT_W-1:0] count, logic ovf);
		out_word_t r;
		r.event_valid = valid;
		r.event_code = code;
		r.queue_count = count;
		r.overflow = ovf;
		return r;
	endfunction

	// mostly plausible scans: small time steps, a few keys changing, the encoder walking
	function automatic in_word_t random_word(int unsigned pop_pct);
		in_word_t w;
		int unsigned pick;
		w = make_word(CMD_POP, MASK_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
			$urandom);
		if ($urandom_range(0, 99) < pop_pct)
			return w;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			sim_now = $urandom;
		else if (pick < 10)
			sim_now += $urandom_range(0, 70000);
		else
			sim_now += $urandom_range(0, 150);
		if ($urandom_range(0, 19) == 0) begin
			sim_keys = MASK_W'($urandom);
		end else begin
			repeat ($urandom_range(0, 3))
				sim_keys ^= MASK_W'(1) << $urandom_range(0, NPOS - 1);
		end
		if ($urandom_range(0, 6) == 0)
			sim_enc_step = 2'($urandom);
		else if ($urandom_range(0, 1) != 0)
			sim_enc_step += 2'd1;
		else
			sim_enc_step -= 2'd1;
		if ($urandom_range(0, 6) == 0)
			sim_button = ~sim_button;
		// gray walk 11, 10, 00, 01
		return make_word(CMD_SCAN, sim_keys, ~sim_enc_step[1], ~(sim_enc_step[1] ^ sim_enc_step[0]),
			sim_button, sim_now);
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		failures++;
		if (failures <= 40)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic send_word(in_word_t w, logic typed, out_word_t typed_want);
		out_word_t model;
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		model = scan_or_pop(w);
		expected_results.push_back(typed ? typed_want : model);
		words_sent++;
	endtask

	task automatic drain(int unsigned settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
		REG_VALID_KEY_MASK: key_mask = value[MASK_W-1:0];
		REG_RELEASE_GUARD: release_guard = value[GUARD_W-1:0];
		default: button_guard = value[GUARD_W-1:0];
		endcase
		writes_done++;
	endtask

	// receiver side: random stall bursts
	always @(negedge clk) begin
		if (idle_pct == 0) begin
			out_stall <= 1'b0;
		end else if (stall_run != 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 99) < idle_pct / 3) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with nothing pending, code", out_word.event_code, 0);
			end else begin
				want = expected_results.pop_front();
				results_seen++;
				if (want.event_valid)
					events_popped++;
				if (want.overflow)
					overflow_scans++;
				if (out_word.event_valid !== want.event_valid)
					report_mismatch("event_valid", out_word.event_valid, want.event_valid);
				if (out_word.event_code !== want.event_code)
					report_mismatch("event_code", out_word.event_code, want.event_code);
				if (out_word.queue_count !== want.queue_count)
					report_mismatch("queue_count", out_word.queue_count, want.queue_count);
				if (out_word.overflow !== want.overflow)
					report_mismatch("overflow", out_word.overflow, want.overflow);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d results still pending", expected_results.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		stim_row_t plan [25];
		int unsigned pop_pct;
		int unsigned count;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_VALID_KEY_MASK;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;

		// presses spaced just past the release guard fill the queue eighteen keys at a time until it overflows
		plan[0] = '{make_word(CMD_POP, ALL_UP, 0, 0, 1, 0), 1'b1, result_word(0, 0, 0, 0)};
		plan[1] = '{make_word(CMD_SCAN, ALL_UP, 0, 0, 1, 0), 1'b1, result_word(0, 0, 0, 0)};
		plan[2] = '{make_word(CMD_SCAN, ALL_DOWN, 1, 1, 1, 10), 1'b0, '0};
		plan[3] = '{make_word(CMD_SCAN, ALL_DOWN, 1, 0, 0, 50), 1'b0, '0};
		plan[4] = '{make_word(CMD_SCAN, ALL_UP, 1, 1, 0, 110), 1'b0, '0};
		plan[5] = '{make_word(CMD_SCAN, ALL_UP, 0, 1, 1, 111), 1'b0, '0};
		plan[6] = '{make_word(CMD_SCAN, ALL_DOWN, 0, 0, 1, 112), 1'b0, '0};
		plan[7] = '{make_word(CMD_SCAN, ALL_UP, 0, 0, 1, 213), 1'b0, '0};
		plan[8] = '{make_word(CMD_SCAN, ALL_DOWN, 0, 0, 1, 214), 1'b0, '0};
		plan[9] = '{make_word(CMD_SCAN, ALL_UP, 0, 0, 1, 315), 1'b0, '0};
		plan[10] = '{make_word(CMD_SCAN, ALL_DOWN, 0, 0, 1, 316), 1'b0, '0};
		plan[11] = '{make_word(CMD_SCAN, ALL_UP, 0, 0, 1, 417), 1'b0, '0};
		plan[12] = '{make_word(CMD_SCAN, ALL_DOWN, 0, 0, 1, 418), 1'b0, '0};
		plan[13] = '{make_word(CMD_SCAN, ALL_UP, 0, 0, 1, 519), 1'b0, '0};
		plan[14] = '{make_word(CMD_SCAN, ALL_DOWN, 0, 0, 1, 520), 1'b0, '0};
		plan[15] = '{make_word(CMD_SCAN, ALL_UP, 0, 0, 1, 621), 1'b0, '0};
		plan[16] = '{make_word(CMD_SCAN, ALL_DOWN, 0, 0, 1, 622), 1'b1,
			result_word(0, 0, COUNT_W'(QUEUE_DEPTH_DEF), 1)};
		plan[17] = '{make_word(CMD_POP, ALL_UP, 0, 0, 1, 0), 1'b1,
			result_word(1, 0, COUNT_W'(QUEUE_DEPTH_DEF - 1), 0)};
		// scan fields on a pop are ignored
		plan[18] = '{make_word(CMD_POP, ALL_DOWN, 1, 1, 0, '1), 1'b0, '0};
		plan[19] = '{make_word(CMD_SCAN, ALL_UP, 1, 1, 0, '1), 1'b0, '0};
		// time wraps past zero here
		plan[20] = '{make_word(CMD_SCAN, ALL_DOWN, 1, 0, 0, 5), 1'b0, '0};
		plan[21] = '{make_word(CMD_SCAN, VALID_KEY_MASK_RST, 0, 1, 1, 32'h70), 1'b0, '0};
		plan[22] = '{make_word(CMD_POP, ALL_UP, 0, 0, 1, 0), 1'b0, '0};
		plan[23] = '{make_word(CMD_POP, ALL_UP, 0, 0, 1, 0), 1'b0, '0};
		plan[24] = '{make_word(CMD_SCAN, 25'h0AAAAAA, 0, 0, 1, 32'h80), 1'b0, '0};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_word(plan[i].word, plan[i].typed, plan[i].want);

		sim_now = 32'd1000;
		for (int ph = 0; ph < 6; ph++) begin
			drain(SETTLE_CYCLES);
			case (ph)
			0: begin
				pop_pct = 45;
				idle_pct = 30;
				count = 200;
			end
			1: begin
				write_reg(REG_VALID_KEY_MASK, '1);
				write_reg(REG_RELEASE_GUARD, '0);
				write_reg(REG_BUTTON_GUARD, '0);
				pop_pct = 20;
				idle_pct = 35;
				count = 220;
			end
			2: begin
				write_reg(REG_VALID_KEY_MASK, '0);
				write_reg(REG_RELEASE_GUARD, CFG_DATA_W'(16'hFFFF));
				write_reg(REG_BUTTON_GUARD, CFG_DATA_W'(16'hFFFF));
				pop_pct = 50;
				idle_pct = 20;
				count = 150;
			end
			3: begin
				write_reg(REG_VALID_KEY_MASK, CFG_DATA_W'($urandom));
				write_reg(REG_RELEASE_GUARD, CFG_DATA_W'($urandom_range(0, 300)));
				write_reg(REG_BUTTON_GUARD, CFG_DATA_W'($urandom_range(0, 300)));
				pop_pct = 55;
				idle_pct = 45;
				count = 220;
			end
			4: begin
				write_reg(REG_VALID_KEY_MASK, CFG_DATA_W'($urandom));
				write_reg(REG_RELEASE_GUARD, CFG_DATA_W'($urandom_range(0, 65535)));
				write_reg(REG_BUTTON_GUARD, CFG_DATA_W'($urandom_range(0, 65535)));
				sim_now = 32'hFFFF_F000;
				pop_pct = 25;
				idle_pct = 30;
				count = 200;
			end
			default: begin
				write_reg(REG_VALID_KEY_MASK, CFG_DATA_W'(VALID_KEY_MASK_RST));
				write_reg(REG_RELEASE_GUARD, CFG_DATA_W'($urandom_range(0, 200)));
				write_reg(REG_BUTTON_GUARD, CFG_DATA_W'($urandom_range(0, 200)));
				pop_pct = 45;
				idle_pct = 0;
				count = 300;
			end
			endcase
			for (int n = 0; n < count; n++) begin
				// hold off once per phase until the queue of results is empty
				if (n == count / 2)
					drain(0);
				send_word(random_word(pop_pct), 1'b0, '0);
			end
		end

		drain(SETTLE_CYCLES);
		$display("%0d words sent, %0d result words checked, %0d register writes",
			words_sent, results_seen, writes_done);
		$display("%0d pops returned an event, %0d scans dropped events on a full queue",
			events_popped, overflow_scans);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
